/* rtl/asgr_pkg.sv */
`timescale 1ns / 1ps
package asgr_pkg;

  // ascii bytes used by the sequencer
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_TERM  = 8'h6D;  // 'm'
  localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CH_THREE = 8'h33;  // '3'
  localparam logic [7:0] CH_FOUR  = 8'h34;  // '4'
  localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'
  localparam logic [3:0] DIGIT_HI = 4'h3;   // upper nibble of '0'..'9'

  localparam int unsigned STYLE_W = 7;
  localparam int unsigned RGB_W   = 24;

  localparam logic [23:0] WHITE_RGB = 24'hFFFFFF;
  localparam logic [23:0] BLACK_RGB = 24'h000000;

  // one request as handed from the front to the back
  typedef struct packed {
    logic [STYLE_W-1:0] style_diff;
    logic [STYLE_W-1:0] style_new;
    logic [RGB_W-1:0]   back_rgb;
    logic [RGB_W-1:0]   fore_rgb;
    logic               do_back;
    logic               do_fore;
  } job_t;

  // sgr code written when a style bit turns on
  function automatic logic [7:0] on_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h31;  // bold
      3'd1:    c = 8'h34;  // underline
      3'd2:    c = 8'h33;  // italic
      3'd3:    c = 8'h39;  // strike
      3'd4:    c = 8'h35;  // blink
      3'd5:    c = 8'h37;  // inverse
      3'd6:    c = 8'h38;  // hidden
      default: c = 8'h30;
    endcase
    return c;
  endfunction

  // second digit of the "2x" off code
  function automatic logic [7:0] off_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h32;
      3'd1:    c = 8'h34;
      3'd2:    c = 8'h33;
      3'd3:    c = 8'h39;
      3'd4:    c = 8'h35;
      3'd5:    c = 8'h37;
      3'd6:    c = 8'h38;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

  // index of the lowest set bit
  function automatic logic [2:0] lowest_bit(input logic [STYLE_W-1:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = STYLE_W - 1; i >= 0; i--) begin
      if (m[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // double dabble: byte to three bcd digits {hundreds, tens, ones}
  function automatic logic [11:0] bin_to_bcd(input logic [7:0] v);
    logic [19:0] s;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8]  >= 4'd5) s[11:8]  = s[11:8]  + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = s << 1;
    end
    return s[19:8];
  endfunction

endpackage

/* rtl/asgr_front.sv */
`timescale 1ns / 1ps
module asgr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [6:0]       in_style_mask,
  input  logic [7:0]       in_back_red,
  input  logic [7:0]       in_back_green,
  input  logic [7:0]       in_back_blue,
  input  logic [7:0]       in_fore_red,
  input  logic [7:0]       in_fore_green,
  input  logic [7:0]       in_fore_blue,
  input  logic             in_force_all,
  input  logic             in_frame_start,
  input  logic             q_full,
  output logic             q_push,
  output asgr_pkg::job_t   q_job
);
  import asgr_pkg::*;

  logic [STYLE_W-1:0] trk_style_r, trk_style_nxt;
  logic [RGB_W-1:0]   trk_back_r, trk_back_nxt;
  logic [RGB_W-1:0]   trk_fore_r, trk_fore_nxt;

  logic [STYLE_W-1:0] old_style;
  logic [RGB_W-1:0]   old_back, old_fore, cell_back, cell_fore;
  logic               accept, do_back, do_fore;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign cell_back = {in_back_red, in_back_green, in_back_blue};
  assign cell_fore = {in_fore_red, in_fore_green, in_fore_blue};

  // frame start sees the reset tracking
  assign old_style = in_frame_start ? '0        : trk_style_r;
  assign old_back  = in_frame_start ? BLACK_RGB : trk_back_r;
  assign old_fore  = in_frame_start ? WHITE_RGB : trk_fore_r;

  assign do_back = in_force_all || (cell_back != old_back);
  assign do_fore = in_force_all || (cell_fore != old_fore);

  // cells that change nothing are dropped here
  assign q_push = accept && ((in_style_mask != old_style) || do_back || do_fore);

  always_comb begin
    q_job.style_diff = in_style_mask ^ old_style;
    q_job.style_new  = in_style_mask;
    q_job.back_rgb   = cell_back;
    q_job.fore_rgb   = cell_fore;
    q_job.do_back    = do_back;
    q_job.do_fore    = do_fore;
  end

  // after any accepted cell the tracking equals that cell
  always_comb begin
    trk_style_nxt = trk_style_r;
    trk_back_nxt  = trk_back_r;
    trk_fore_nxt  = trk_fore_r;
    if (accept) begin
      trk_style_nxt = in_style_mask;
      trk_back_nxt  = cell_back;
      trk_fore_nxt  = cell_fore;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_style_r <= '0;
      trk_back_r  <= BLACK_RGB;
      trk_fore_r  <= WHITE_RGB;
    end else begin
      trk_style_r <= trk_style_nxt;
      trk_back_r  <= trk_back_nxt;
      trk_fore_r  <= trk_fore_nxt;
    end
  end

endmodule

/* rtl/asgr_queue.sv */
`timescale 1ns / 1ps
module asgr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  asgr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output asgr_pkg::job_t head_job
);
  import asgr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign head_job = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

/* rtl/asgr_back.sv */
`timescale 1ns / 1ps
module asgr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  asgr_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_byte
);
  import asgr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LBR,
    ST_STYLE,
    ST_LEAD,
    ST_EIGHT,
    ST_SEPA,
    ST_TWO,
    ST_SEPB,
    ST_DIGIT,
    ST_SEPC
  } state_t;

  state_t             state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [STYLE_W-1:0] rem_r, rem_nxt, rem_clr;
  logic [1:0]         sub_r, sub_nxt;
  logic               col_r, col_nxt;
  logic [1:0]         comp_r, comp_nxt;
  logic [1:0]         dig_r, dig_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;

  logic               adv, emit, last_v;
  logic [7:0]         byte_v;
  logic [2:0]         bit_idx;
  logic               bit_new;
  logic [RGB_W-1:0]   rgb;
  logic [7:0]         comp_val;
  logic [11:0]        bcd;
  logic [1:0]         first_dig, eff_dig;
  logic [3:0]         dig_val;

  assign adv = !out_valid_r || !out_stall;

  assign bit_idx = lowest_bit(rem_r);
  assign bit_new = job_r.style_new[bit_idx];
  assign rem_clr = rem_r & (rem_r - 1'b1);

  assign rgb = col_r ? job_r.fore_rgb : job_r.back_rgb;
  always_comb begin
    case (comp_r)
      2'd0:    comp_val = rgb[23:16];
      2'd1:    comp_val = rgb[15:8];
      default: comp_val = rgb[7:0];
    endcase
  end
  assign bcd = bin_to_bcd(comp_val);

  // leading zeros are skipped
  assign first_dig = (comp_val >= 8'd100) ? 2'd0 : (comp_val >= 8'd10) ? 2'd1 : 2'd2;
  assign eff_dig   = (dig_r > first_dig) ? dig_r : first_dig;
  always_comb begin
    case (eff_dig)
      2'd0:    dig_val = bcd[11:8];
      2'd1:    dig_val = bcd[7:4];
      default: dig_val = bcd[3:0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    rem_nxt   = rem_r;
    sub_nxt   = sub_r;
    col_nxt   = col_r;
    comp_nxt  = comp_r;
    dig_nxt   = dig_r;
    emit      = 1'b1;
    last_v    = 1'b0;
    byte_v    = CH_SEMI;
    q_pop     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        emit   = !q_empty;
        byte_v = CH_ESC;
        if (!q_empty) begin
          q_pop     = adv;
          job_nxt   = q_job;
          rem_nxt   = q_job.style_diff;
          state_nxt = ST_LBR;
        end
      end
      ST_LBR: begin
        byte_v = CH_LBR;
        if (rem_r != '0) begin
          sub_nxt   = 2'd0;
          state_nxt = ST_STYLE;
        end else begin
          col_nxt   = !job_r.do_back;
          state_nxt = ST_LEAD;
        end
      end
      ST_STYLE: begin
        if (sub_r == 2'd0) begin
          byte_v  = bit_new ? on_char(bit_idx) : CH_TWO;
          sub_nxt = 2'd1;
        end else if (sub_r == 2'd1 && !bit_new) begin
          byte_v  = off_char(bit_idx);
          sub_nxt = 2'd2;
        end else begin
          // separator or closing 'm' after this code
          rem_nxt = rem_clr;
          sub_nxt = 2'd0;
          if (rem_clr == '0) begin
            if (job_r.do_back || job_r.do_fore) begin
              byte_v    = CH_SEMI;
              col_nxt   = !job_r.do_back;
              state_nxt = ST_LEAD;
            end else begin
              byte_v    = CH_TERM;
              last_v    = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            byte_v = CH_SEMI;
          end
        end
      end
      ST_LEAD: begin
        byte_v    = col_r ? CH_THREE : CH_FOUR;
        state_nxt = ST_EIGHT;
      end
      ST_EIGHT: begin
        byte_v    = CH_EIGHT;
        state_nxt = ST_SEPA;
      end
      ST_SEPA: begin
        byte_v    = CH_SEMI;
        state_nxt = ST_TWO;
      end
      ST_TWO: begin
        byte_v    = CH_TWO;
        state_nxt = ST_SEPB;
      end
      ST_SEPB: begin
        byte_v    = CH_SEMI;
        comp_nxt  = 2'd0;
        dig_nxt   = 2'd0;
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        byte_v  = {DIGIT_HI, dig_val};
        dig_nxt = eff_dig + 2'd1;
        if (eff_dig == 2'd2) state_nxt = ST_SEPC;
      end
      ST_SEPC: begin
        if (comp_r != 2'd2) begin
          byte_v    = CH_SEMI;
          comp_nxt  = comp_r + 2'd1;
          dig_nxt   = 2'd0;
          state_nxt = ST_DIGIT;
        end else if (!col_r && job_r.do_fore) begin
          byte_v    = CH_SEMI;
          col_nxt   = 1'b1;
          state_nxt = ST_LEAD;
        end else begin
          byte_v    = CH_TERM;
          last_v    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        emit      = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = emit;
      out_byte_nxt  = byte_v;
      out_last_nxt  = last_v;
    end else begin
      // hold everything while the output is stalled
      state_nxt = state_r;
      job_nxt   = job_r;
      rem_nxt   = rem_r;
      sub_nxt   = sub_r;
      col_nxt   = col_r;
      comp_nxt  = comp_r;
      dig_nxt   = dig_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    rem_r      <= rem_nxt;
    sub_r      <= sub_nxt;
    col_r      <= col_nxt;
    comp_r     <= comp_nxt;
    dig_r      <= dig_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

/* rtl/ansi_sgr_color_delta_encoder.sv */
`timescale 1ns / 1ps
// channel   handshake          payload
// input     in_valid/in_stall  in_style_mask, in_back_*, in_fore_*, in_force_all, in_frame_start
// output    out_valid/out_stall out_byte, out_last_byte
//
// one byte leaves per cycle while out_stall is low, and a cell gives 0 to 57 bytes;
// the byte sequencer in the back end sets that figure
// a cell that changes nothing is absorbed without a queue entry and gives no bytes
// reset (rst_n low at a clock edge) sets style 0, black background, white foreground
// and empties the request queue
// out_stall freezes the sequencer; the queue then fills and raises in_stall
module ansi_sgr_color_delta_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2  // requests buffered between front and back
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [6:0] in_style_mask,
  input  logic [7:0] in_back_red,
  input  logic [7:0] in_back_green,
  input  logic [7:0] in_back_blue,
  input  logic [7:0] in_fore_red,
  input  logic [7:0] in_fore_green,
  input  logic [7:0] in_fore_blue,
  input  logic       in_force_all,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);
  import asgr_pkg::*;

  // front to queue
  logic q_push, q_full;
  job_t push_job;

  // queue to back
  logic q_pop, q_empty;
  job_t head_job;

  // front: tracks the last emitted attributes and decides what must be written;
  // it accepts a cell every cycle while the queue has room
  asgr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_style_mask  (in_style_mask),
    .in_back_red    (in_back_red),
    .in_back_green  (in_back_green),
    .in_back_blue   (in_back_blue),
    .in_fore_red    (in_fore_red),
    .in_fore_green  (in_fore_green),
    .in_fore_blue   (in_fore_blue),
    .in_force_all   (in_force_all),
    .in_frame_start (in_frame_start),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  // short request queue so both sides stall independently
  asgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  // back: walks ESC '[' style codes, colors and 'm', one byte per cycle into
  // the output register while out_stall is low; a waiting request's ESC follows the 'm' with no gap
  asgr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_job         (head_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
